[hw/rtl/rtbes_pkg.sv]
// package for the reach table best entry selector
// widths, codes, entry layout and controller/datapath command types; no dependencies
package rtbes_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int ID_W     = 16;
    localparam int RATE_W   = 16;
    localparam int REACH_W  = 16;
    localparam int SLICES_W = 14;

    localparam logic [SLICES_W-1:0] SLICE_LIMIT = SLICES_W'(10000);

    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,
        KIND_QUERY = 2'd1,
        KIND_CLEAR = 2'd2
    } t_kind;

    typedef struct packed {
        logic [ID_W-1:0]     id;
        logic [RATE_W-1:0]   rate;
        logic [REACH_W-1:0]  reach;
        logic [SLICES_W-1:0] slices;
    } t_entry;

    typedef struct packed {
        logic load;
        logic clear;
        logic start;
        logic read;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic count_zero;
        logic last_addr;
    } t_dp_stat;

endpackage

[hw/rtl/rtbes_if.sv]
// valid/ready channel interfaces for input and result words
// depends on rtbes_pkg for field widths
interface rtbes_in_if
    import rtbes_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [1:0]          kind;
    logic [ID_W-1:0]     entry_id;
    logic [RATE_W-1:0]   rate;
    logic [REACH_W-1:0]  reach;
    logic [SLICES_W-1:0] slices;

    modport source (output valid, kind, entry_id, rate, reach, slices, input ready);
    modport sink   (input valid, kind, entry_id, rate, reach, slices, output ready);
endinterface

interface rtbes_out_if
    import rtbes_pkg::*;
;
    logic                valid;
    logic                ready;
    logic                found;
    logic [ID_W-1:0]     best_id;
    logic [RATE_W-1:0]   best_rate;
    logic [REACH_W-1:0]  best_reach;
    logic [SLICES_W-1:0] best_slices;

    modport source (output valid, found, best_id, best_rate, best_reach, best_slices,
                    input ready);
    modport sink   (input valid, found, best_id, best_rate, best_reach, best_slices,
                    output ready);
endinterface

[hw/rtl/rtbes_datapath.sv]
// datapath: option memory, entry count, scan address, compare stage and result register
// depends on rtbes_pkg
module rtbes_datapath
    import rtbes_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    output t_dp_stat            o_stat,
    input  logic [ID_W-1:0]     i_entry_id,
    input  logic [RATE_W-1:0]   i_rate,
    input  logic [REACH_W-1:0]  i_reach,
    input  logic [SLICES_W-1:0] i_slices,
    output logic                o_found,
    output t_entry              o_best
);

    t_entry              r_mem [TABLE_DEPTH];
    t_entry              r_rd_data;
    logic                r_rd_vld;
    logic [CNT_W-1:0]    r_count;
    logic [ADDR_W-1:0]   r_addr;
    logic [RATE_W-1:0]   r_q_rate;
    logic [REACH_W-1:0]  r_q_reach;
    logic [SLICES_W-1:0] r_min;
    logic                r_found;
    t_entry              r_best;
    logic                r_out_found;
    t_entry              r_out_best;
    logic                qualify;

    assign o_stat.count_zero = (r_count == '0);
    assign o_stat.last_addr  = ((CNT_W'(r_addr) + CNT_W'(1)) == r_count);

    assign qualify = r_rd_vld && (r_rd_data.rate == r_q_rate) &&
                     (r_rd_data.reach >= r_q_reach) && (r_rd_data.slices <= r_min);

    // table storage
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && (r_count < CNT_W'(TABLE_DEPTH))) begin
            r_mem[r_count[ADDR_W-1:0]] <= '{id: i_entry_id, rate: i_rate,
                                            reach: i_reach, slices: i_slices};
        end
        if (i_cmd.read) begin
            r_rd_data <= r_mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_rd_vld <= 1'b0;
            r_addr   <= '0;
        end else begin
            r_rd_vld <= i_cmd.read;
            if (i_cmd.clear) begin
                r_count <= '0;
            end else if (i_cmd.load && (r_count < CNT_W'(TABLE_DEPTH))) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.start) begin
                r_addr <= '0;
            end else if (i_cmd.read) begin
                r_addr <= r_addr + ADDR_W'(1);
            end
        end
    end

    // running minimum, later entry wins on a tie
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_q_rate  <= i_rate;
            r_q_reach <= i_reach;
            r_min     <= SLICE_LIMIT;
            r_found   <= 1'b0;
            r_best    <= '0;
        end else if (qualify) begin
            r_min   <= r_rd_data.slices;
            r_found <= 1'b1;
            r_best  <= r_rd_data;
        end
        if (i_cmd.emit) begin
            r_out_found <= r_found;
            r_out_best  <= r_best;
        end
    end

    assign o_found = r_out_found;
    assign o_best  = r_out_best;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_DEPTH))
        else $error("entry count above table depth");

    a_read_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.read |-> (CNT_W'(r_addr) < r_count))
        else $error("scan read beyond loaded entries");

    a_emit_settled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> !r_rd_vld && !i_cmd.read)
        else $error("result taken while a compare is pending");

endmodule

[hw/rtl/rtbes_ctrl.sv]
// controller: decodes accepted words, sequences the scan and owns result valid
// depends on rtbes_pkg
module rtbes_ctrl
    import rtbes_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_kind,
    output logic       o_in_ready,
    input  logic       i_out_ready,
    output logic       o_out_valid,
    input  t_dp_stat   i_stat,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   accept;

    assign o_in_ready  = (r_state == S_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_kind)
                        KIND_LOAD:  o_cmd.load  = 1'b1;
                        KIND_CLEAR: o_cmd.clear = 1'b1;
                        KIND_QUERY: begin
                            o_cmd.start = 1'b1;
                            n_state     = i_stat.count_zero ? S_DONE : S_SCAN;
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN: begin
                o_cmd.read = 1'b1;
                if (i_stat.last_addr) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.emit  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |=> r_out_valid)
        else $error("result word not raised after emit");

    a_scan_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN || r_state == S_DRAIN) |-> !o_cmd.load && !o_cmd.clear)
        else $error("table changed during a scan");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !o_cmd.emit)
        else $error("pending result overwritten");

endmodule

[hw/rtl/reach_table_best_entry_select.sv]
// top level of the reach table best entry selector
// depends on rtbes_pkg, rtbes_in_if/rtbes_out_if, rtbes_ctrl and rtbes_datapath
//
// channel | dir | word
// i_in    | in  | kind, entry_id, rate, reach, slices
// o_out   | out | found, best_id, best_rate, best_reach, best_slices
//
// load, clear and unused kinds are handled in the idle state, which they do not leave
// a query reads the memory once per loaded entry, compares after the last read,
// then registers the result; an empty table skips the reads and the compare
// result waits in an output register; a stalled result holds only the next query's end
// reset clears the entry count; table memory needs no clearing
module reach_table_best_entry_select
    import rtbes_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    rtbes_in_if.sink     i_in,
    rtbes_out_if.source  o_out
);

    t_dp_cmd  cmd;
    t_dp_stat stat;
    t_entry   best;
    logic     in_ready;
    logic     out_valid;
    logic     found;

    rtbes_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_kind      (i_in.kind),
        .o_in_ready  (in_ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (out_valid),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    rtbes_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_entry_id (i_in.entry_id),
        .i_rate     (i_in.rate),
        .i_reach    (i_in.reach),
        .i_slices   (i_in.slices),
        .o_found    (found),
        .o_best     (best)
    );

    assign i_in.ready        = in_ready;
    assign o_out.valid       = out_valid;
    assign o_out.found       = found;
    assign o_out.best_id     = best.id;
    assign o_out.best_rate   = best.rate;
    assign o_out.best_reach  = best.reach;
    assign o_out.best_slices = best.slices;

endmodule
